[src/pms_pkg.sv]
`timescale 1ns / 1ps
// pms_pkg: shared widths, constants, speed ratio table and stage structs
// for the pointer motion scaler. No dependencies.

package pms_pkg;

  localparam int unsigned SPEED_LEVELS = 16;
  localparam int unsigned LVL_W        = 5;
  localparam int unsigned LVL_IDX_W    = $clog2(SPEED_LEVELS);
  localparam int unsigned DELTA_W      = 8;
  localparam int unsigned MAG_W        = 8;
  localparam int unsigned OUT_W        = 12;
  localparam int          OUT_MAX      = 1120;
  localparam int unsigned NUM_W        = 6;
  localparam int unsigned SQ_W         = 14;
  localparam int unsigned FACT_W       = 12;
  localparam int unsigned SCALE_W      = 18;
  localparam int unsigned PROD_W       = 25;
  localparam int unsigned XW           = 18;
  localparam int unsigned QW           = 11;
  localparam int unsigned DIV_W        = 7;
  localparam int unsigned RECIP_W      = 16;
  localparam int unsigned RECIP_SH     = 18;

  // acceleration factor in thousandths
  localparam logic [FACT_W-1:0] FACT_SLOW  = 12'd600;
  localparam logic [FACT_W-1:0] FACT_MID   = 12'd800;
  localparam int unsigned       FACT_BASE  = 1000;
  localparam int unsigned       FACT_SLOPE = 30;
  localparam logic [FACT_W-1:0] FACT_CAP   = 12'd3500;

  // 16000 = 128 * 125, 16 = shift by 4
  localparam int unsigned ACCEL_SH   = 7;
  localparam int unsigned PLAIN_SH   = 4;
  localparam logic [DIV_W-1:0] DIV_PREC  = 7'd6;
  localparam logic [DIV_W-1:0] DIV_ACCEL = 7'd125;
  localparam logic [DIV_W-1:0] DIV_PLAIN = 7'd1;
  // floor(2^18 / divisor)
  localparam logic [RECIP_W-1:0] RECIP_PREC  = 16'd43690;
  localparam logic [RECIP_W-1:0] RECIP_ACCEL = 16'd2097;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEVEL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE = 4'd1;

  localparam logic [LVL_W-1:0] GAIN_LEVEL_RST = 5'd8;

  typedef enum logic [1:0] {
    MODE_PREC,
    MODE_PLAIN,
    MODE_ACCEL
  } mode_e;

  typedef struct packed {
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic              neg_x;
    logic              neg_y;
    logic              nz_x;
    logic              nz_y;
    mode_e             mode;
    logic [NUM_W-1:0]  num;
    logic [FACT_W-1:0] factor;
  } front_t;

  typedef struct packed {
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic              neg_x;
    logic              neg_y;
    logic              nz_x;
    logic              nz_y;
    mode_e             mode;
  } prod_t;

  function automatic logic [NUM_W-1:0] ratio_num(input logic [LVL_IDX_W-1:0] idx);
    logic [NUM_W-1:0] n;
    case (idx)
      4'd0:    n = 6'd40;
      4'd1:    n = 6'd36;
      4'd2:    n = 6'd32;
      4'd3:    n = 6'd28;
      4'd4:    n = 6'd24;
      4'd5:    n = 6'd20;
      4'd6:    n = 6'd18;
      4'd7:    n = 6'd16;
      4'd8:    n = 6'd14;
      4'd9:    n = 6'd12;
      4'd10:   n = 6'd10;
      4'd11:   n = 6'd8;
      4'd12:   n = 6'd6;
      4'd13:   n = 6'd5;
      4'd14:   n = 6'd4;
      default: n = 6'd3;
    endcase
    return n;
  endfunction

endpackage

[src/pms_front.sv]
`timescale 1ns / 1ps
// pms_front: first two pipeline stages, magnitudes, speed ratio lookup
// and acceleration factor. Depends on pms_pkg.

module pms_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [pms_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [pms_pkg::DELTA_W-1:0] delta_y_i,
  input  logic                               precision_mode_i,
  input  logic [pms_pkg::LVL_W-1:0]          gain_level_i,
  input  logic                               accel_enable_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pms_pkg::front_t                    out_o
);
  import pms_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             neg_x;
    logic             neg_y;
    logic             nz_x;
    logic             nz_y;
    mode_e            mode;
    logic [NUM_W-1:0] num;
    logic             v_le1;
    logic             v_eq2;
    logic [SQ_W-1:0]  sq;
  } stage_a_t;

  stage_a_t a_d, a_q;
  front_t   b_d, b_q;
  logic     va_q, vb_q;
  logic     rdy_a, rdy_b;

  logic [MAG_W-1:0]     ax, ay, v, vm3;
  logic [DIV_W-1:0]     excess;
  logic [LVL_W-1:0]     lvl;
  logic [FACT_W+6:0]    fact_raw;

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // stage a: magnitudes, peak, squared distance past 3, ratio numerator
  always_comb begin
    ax     = delta_x_i[DELTA_W-1] ? MAG_W'(~delta_x_i + 1'b1) : MAG_W'(delta_x_i);
    ay     = delta_y_i[DELTA_W-1] ? MAG_W'(~delta_y_i + 1'b1) : MAG_W'(delta_y_i);
    v      = (ax > ay) ? ax : ay;
    vm3    = v - MAG_W'(3);
    excess = (v >= MAG_W'(3)) ? vm3[DIV_W-1:0] : '0;

    lvl = gain_level_i;
    if (lvl == '0) begin
      lvl = LVL_W'(1);
    end else if (lvl > LVL_W'(SPEED_LEVELS)) begin
      lvl = LVL_W'(SPEED_LEVELS);
    end

    a_d.ax    = ax;
    a_d.ay    = ay;
    a_d.neg_x = delta_x_i[DELTA_W-1];
    a_d.neg_y = delta_y_i[DELTA_W-1];
    a_d.nz_x  = (ax != '0);
    a_d.nz_y  = (ay != '0);
    if (precision_mode_i) begin
      a_d.mode = MODE_PREC;
    end else if (accel_enable_i) begin
      a_d.mode = MODE_ACCEL;
    end else begin
      a_d.mode = MODE_PLAIN;
    end
    a_d.num   = ratio_num(LVL_IDX_W'(lvl - LVL_W'(1)));
    a_d.v_le1 = (v <= MAG_W'(1));
    a_d.v_eq2 = (v == MAG_W'(2));
    a_d.sq    = SQ_W'(excess) * SQ_W'(excess);
  end

  // stage b: acceleration factor with cap
  always_comb begin
    fact_raw = (FACT_W+7)'(FACT_BASE) + (FACT_W+7)'(FACT_SLOPE) * (FACT_W+7)'(a_q.sq);
    b_d.ax    = a_q.ax;
    b_d.ay    = a_q.ay;
    b_d.neg_x = a_q.neg_x;
    b_d.neg_y = a_q.neg_y;
    b_d.nz_x  = a_q.nz_x;
    b_d.nz_y  = a_q.nz_y;
    b_d.mode  = a_q.mode;
    b_d.num   = a_q.num;
    if (a_q.v_le1) begin
      b_d.factor = FACT_SLOW;
    end else if (a_q.v_eq2) begin
      b_d.factor = FACT_MID;
    end else if (fact_raw > (FACT_W+7)'(FACT_CAP)) begin
      b_d.factor = FACT_CAP;
    end else begin
      b_d.factor = fact_raw[FACT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_q <= a_d;
    end
    if (rdy_b && va_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_o       = b_q;

endmodule

[src/pms_mult.sv]
`timescale 1ns / 1ps
// pms_mult: two multiply stages, combined scale then delta times scale.
// Depends on pms_pkg.

module pms_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pms_pkg::front_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pms_pkg::prod_t  out_o
);
  import pms_pkg::*;

  localparam int unsigned PW = MAG_W + SCALE_W;

  typedef struct packed {
    logic [MAG_W-1:0]   ax;
    logic [MAG_W-1:0]   ay;
    logic               neg_x;
    logic               neg_y;
    logic               nz_x;
    logic               nz_y;
    mode_e              mode;
    logic [SCALE_W-1:0] scale;
  } stage_c_t;

  stage_c_t c_d, c_q;
  prod_t    d_d, d_q;
  logic     vc_q, vd_q;
  logic     rdy_c, rdy_d;
  logic [PW-1:0] px_w, py_w;

  assign rdy_d      = !vd_q || out_ready_i;
  assign rdy_c      = !vc_q || rdy_d;
  assign in_ready_o = rdy_c;

  // stage c: ratio times factor (thousandths), plain ratio, or 1 in precision mode
  always_comb begin
    c_d.ax    = in_i.ax;
    c_d.ay    = in_i.ay;
    c_d.neg_x = in_i.neg_x;
    c_d.neg_y = in_i.neg_y;
    c_d.nz_x  = in_i.nz_x;
    c_d.nz_y  = in_i.nz_y;
    c_d.mode  = in_i.mode;
    case (in_i.mode)
      MODE_ACCEL: c_d.scale = SCALE_W'(in_i.num) * SCALE_W'(in_i.factor);
      MODE_PLAIN: c_d.scale = SCALE_W'(in_i.num);
      default:    c_d.scale = SCALE_W'(1);
    endcase
  end

  // stage d: magnitude times scale
  always_comb begin
    px_w      = PW'(c_q.ax) * PW'(c_q.scale);
    py_w      = PW'(c_q.ay) * PW'(c_q.scale);
    d_d.px    = px_w[PROD_W-1:0];
    d_d.py    = py_w[PROD_W-1:0];
    d_d.neg_x = c_q.neg_x;
    d_d.neg_y = c_q.neg_y;
    d_d.nz_x  = c_q.nz_x;
    d_d.nz_y  = c_q.nz_y;
    d_d.mode  = c_q.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        vc_q <= in_valid_i;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && in_valid_i) begin
      c_q <= c_d;
    end
    if (rdy_d && vc_q) begin
      d_q <= d_d;
    end
  end

  assign out_valid_o = vd_q;
  assign out_o       = d_q;

endmodule

[src/pms_div.sv]
`timescale 1ns / 1ps
// pms_div: constant division by reciprocal multiply, remainder correction,
// sign restore with nonzero forcing and the output register. Depends on pms_pkg.

module pms_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pms_pkg::prod_t                    in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pms_pkg::OUT_W-1:0]  scaled_x_o,
  output logic signed [pms_pkg::OUT_W-1:0]  scaled_y_o
);
  import pms_pkg::*;

  localparam int unsigned MW = XW + RECIP_W;

  typedef struct packed {
    logic [XW-1:0]    xx;
    logic [XW-1:0]    xy;
    logic [QW-1:0]    q0x;
    logic [QW-1:0]    q0y;
    logic [DIV_W-1:0] dv;
    logic             neg_x;
    logic             neg_y;
    logic             nz_x;
    logic             nz_y;
  } stage_e_t;

  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          neg_x;
    logic          neg_y;
    logic          nz_x;
    logic          nz_y;
  } stage_f_t;

  stage_e_t e_d, e_q;
  stage_f_t f_d, f_q;
  logic     ve_q, vf_q, vg_q;
  logic     rdy_e, rdy_f, rdy_g;
  logic signed [OUT_W-1:0] sx_d, sy_d, sx_q, sy_q;

  logic [XW-1:0]      xx, xy;
  logic [RECIP_W-1:0] recip;
  logic [MW-1:0]      mx, my;
  logic [XW-1:0]      qdx, qdy, rx, ry;
  logic [QW-1:0]      magx, magy;

  assign rdy_g      = !vg_q || out_ready_i;
  assign rdy_f      = !vf_q || rdy_g;
  assign rdy_e      = !ve_q || rdy_f;
  assign in_ready_o = rdy_e;

  // stage e: pre-shift and reciprocal estimate, low by at most one
  always_comb begin
    case (in_i.mode)
      MODE_ACCEL: begin
        xx       = in_i.px[ACCEL_SH +: XW];
        xy       = in_i.py[ACCEL_SH +: XW];
        recip    = RECIP_ACCEL;
        e_d.dv   = DIV_ACCEL;
      end
      MODE_PLAIN: begin
        xx       = in_i.px[PLAIN_SH +: XW];
        xy       = in_i.py[PLAIN_SH +: XW];
        recip    = '0;
        e_d.dv   = DIV_PLAIN;
      end
      default: begin
        xx       = in_i.px[XW-1:0];
        xy       = in_i.py[XW-1:0];
        recip    = RECIP_PREC;
        e_d.dv   = DIV_PREC;
      end
    endcase
    mx = MW'(xx) * MW'(recip);
    my = MW'(xy) * MW'(recip);
    e_d.xx = xx;
    e_d.xy = xy;
    if (in_i.mode == MODE_PLAIN) begin
      e_d.q0x = xx[QW-1:0];
      e_d.q0y = xy[QW-1:0];
    end else begin
      e_d.q0x = mx[RECIP_SH +: QW];
      e_d.q0y = my[RECIP_SH +: QW];
    end
    e_d.neg_x = in_i.neg_x;
    e_d.neg_y = in_i.neg_y;
    e_d.nz_x  = in_i.nz_x;
    e_d.nz_y  = in_i.nz_y;
  end

  // stage f: remainder check and fix-up
  always_comb begin
    qdx = XW'(e_q.q0x) * XW'(e_q.dv);
    qdy = XW'(e_q.q0y) * XW'(e_q.dv);
    rx  = e_q.xx - qdx;
    ry  = e_q.xy - qdy;
    f_d.qx    = (rx >= XW'(e_q.dv)) ? e_q.q0x + QW'(1) : e_q.q0x;
    f_d.qy    = (ry >= XW'(e_q.dv)) ? e_q.q0y + QW'(1) : e_q.q0y;
    f_d.neg_x = e_q.neg_x;
    f_d.neg_y = e_q.neg_y;
    f_d.nz_x  = e_q.nz_x;
    f_d.nz_y  = e_q.nz_y;
  end

  // stage g: a nonzero delta never scales to zero
  always_comb begin
    magx = (f_q.qx == '0 && f_q.nz_x) ? QW'(1) : f_q.qx;
    magy = (f_q.qy == '0 && f_q.nz_y) ? QW'(1) : f_q.qy;
    sx_d = f_q.neg_x ? -$signed(OUT_W'(magx)) : $signed(OUT_W'(magx));
    sy_d = f_q.neg_y ? -$signed(OUT_W'(magy)) : $signed(OUT_W'(magy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else begin
      if (rdy_e) begin
        ve_q <= in_valid_i;
      end
      if (rdy_f) begin
        vf_q <= ve_q;
      end
      if (rdy_g) begin
        vg_q <= vf_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && in_valid_i) begin
      e_q <= e_d;
    end
    if (rdy_f && ve_q) begin
      f_q <= f_d;
    end
    if (rdy_g && vf_q) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  assign out_valid_o = vg_q;
  assign scaled_x_o  = sx_q;
  assign scaled_y_o  = sy_q;

endmodule

[src/pointer_motion_scaler.sv]
`timescale 1ns / 1ps
// Pointer motion scaler: stages a, b (pms_front), c, d (pms_mult), e, f, g (pms_div).
// Throughput one transaction per cycle while not stalled; every stage has its own valid and ready,
// so a stalled result holds only the stages behind it and bubbles are squeezed out.
// Reset clears all stage valids, sets the speed level to 8 and accel_enable to 1.
// Depends on pms_pkg, pms_front, pms_mult, pms_div.

module pointer_motion_scaler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pms_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pms_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pms_pkg::DELTA_W-1:0]    delta_x_i,
  input  logic signed [pms_pkg::DELTA_W-1:0]    delta_y_i,
  input  logic                                  precision_mode_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pms_pkg::OUT_W-1:0]      scaled_x_o,
  output logic signed [pms_pkg::OUT_W-1:0]      scaled_y_o
);
  import pms_pkg::*;

  logic [LVL_W-1:0] gain_level_q;
  logic             accel_enable_q;

  logic   front_valid, front_ready;
  front_t front_data;
  logic   mult_valid, mult_ready;
  prod_t  mult_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_level_q   <= GAIN_LEVEL_RST;
      accel_enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GAIN_LEVEL:   gain_level_q   <= cfg_data_i[LVL_W-1:0];
        REG_ACCEL_ENABLE: accel_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pms_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .delta_x_i        (delta_x_i),
    .delta_y_i        (delta_y_i),
    .precision_mode_i (precision_mode_i),
    .gain_level_i     (gain_level_q),
    .accel_enable_i   (accel_enable_q),
    .out_valid_o      (front_valid),
    .out_ready_i      (front_ready),
    .out_o            (front_data)
  );

  pms_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_data),
    .out_valid_o (mult_valid),
    .out_ready_i (mult_ready),
    .out_o       (mult_data)
  );

  pms_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mult_valid),
    .in_ready_o  (mult_ready),
    .in_i        (mult_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scaled_x_o  (scaled_x_o),
    .scaled_y_o  (scaled_y_o)
  );

endmodule

[src/pms_checker.sv]
`timescale 1ns / 1ps
// pms_checker: port-level assertions for pointer_motion_scaler and the bind
// that attaches them. Depends on pms_pkg.

module pms_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [pms_pkg::OUT_W-1:0] scaled_x_o,
  input logic signed [pms_pkg::OUT_W-1:0] scaled_y_o
);
  import pms_pkg::*;

  // a result not taken stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(scaled_x_o) && $stable(scaled_y_o))
    else $error("result payload changed while stalled");

  // largest gain is 2.5 * 3.5 on a full-scale delta
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scaled_x_o >= -OUT_MAX) && (scaled_x_o <= OUT_MAX))
    else $error("scaled_x out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scaled_y_o >= -OUT_MAX) && (scaled_y_o <= OUT_MAX))
    else $error("scaled_y out of range");

endmodule

bind pointer_motion_scaler pms_checker u_pms_checker (.*);
